>>> src/ipv4_dotted_quad_parser_core_assert.svh
// assertion macros shared by the parser checker
`ifndef IPV4_DOTTED_QUAD_PARSER_CORE_ASSERT_SVH
`define IPV4_DOTTED_QUAD_PARSER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define IPV4DQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ipv4dq check failed: same-cycle rule");

// next-cycle implication, disabled while reset is asserted
`define IPV4DQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ipv4dq check failed: next-cycle rule");

`endif

>>> src/ipv4dq_pkg.sv
// types and constants of the dotted-quad parser
package ipv4dq_pkg;

    // character classes produced by the front end
    localparam logic [2:0] CLS_NUL   = 3'd0;  // zero byte, end of string
    localparam logic [2:0] CLS_SPTAB = 3'd1;  // space or tab
    localparam logic [2:0] CLS_WS    = 3'd2;  // newline, vt, ff, cr
    localparam logic [2:0] CLS_PLUS  = 3'd3;
    localparam logic [2:0] CLS_MINUS = 3'd4;
    localparam logic [2:0] CLS_DIGIT = 3'd5;
    localparam logic [2:0] CLS_DOT   = 3'd6;
    localparam logic [2:0] CLS_OTHER = 3'd7;

    // field phase codes
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_WS     = 2'd1;
    localparam logic [1:0] PH_SIGN   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    // verdict codes
    localparam logic [1:0] VD_PARSING  = 2'd0;
    localparam logic [1:0] VD_ACCEPTED = 2'd1;
    localparam logic [1:0] VD_REJECTED = 2'd2;

    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [8:0] ACC_SAT  = 9'd256;
    localparam logic [8:0] ACC_MAX  = 9'd255;

    typedef struct packed {
        logic       last;
        logic [3:0] digit;
        logic [2:0] cls;
    } token_t;

    typedef struct packed {
        logic [1:0]  field_index;
        logic [1:0]  phase;
        logic [8:0]  acc;
        logic        neg;
        logic [23:0] octets;
        logic [1:0]  verdict;
    } parse_state_t;

    localparam parse_state_t ST_RESET = '{
        field_index: 2'd0,
        phase:       PH_START,
        acc:         9'd0,
        neg:         1'b0,
        octets:      24'd0,
        verdict:     VD_PARSING
    };

endpackage

>>> src/ipv4dq_front.sv
// front end: classifies each incoming byte into a token
module ipv4dq_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // char_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 push_valid,
    input  logic                 push_ready,
    output ipv4dq_pkg::token_t   push_token
);
    import ipv4dq_pkg::*;

    logic [2:0] cls;

    always_comb begin
        if (s_tdata == 8'd0) begin
            cls = CLS_NUL;
        end else if (s_tdata == 8'd32 || s_tdata == 8'd9) begin
            cls = CLS_SPTAB;
        end else if (s_tdata inside {[8'd10:8'd13]}) begin
            cls = CLS_WS;
        end else if (s_tdata == 8'd43) begin
            cls = CLS_PLUS;
        end else if (s_tdata == 8'd45) begin
            cls = CLS_MINUS;
        end else if (s_tdata inside {[8'd48:8'd57]}) begin
            cls = CLS_DIGIT;
        end else if (s_tdata == 8'd46) begin
            cls = CLS_DOT;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign push_token.cls   = cls;
    assign push_token.digit = s_tdata[3:0];
    assign push_token.last  = s_tlast;
    assign push_valid       = s_tvalid;
    assign s_tready         = push_ready;

endmodule

>>> src/ipv4dq_queue.sv
// short token queue between front end and back end
module ipv4dq_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ipv4dq_pkg::token_t   in_token,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ipv4dq_pkg::token_t   out_token
);
    import ipv4dq_pkg::*;

    token_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign in_ready  = (count_reg != QCNT_W'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_token = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_token;
        end
    end

endmodule

>>> src/ipv4dq_back.sv
// back end: field state machine, accumulator and result register
module ipv4dq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  ipv4dq_pkg::token_t   q_token,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // ip_address
    output logic [0:0]           m_tuser    // is_valid
);
    import ipv4dq_pkg::*;

    parse_state_t st_reg, st_next;
    parse_state_t st_byte, st_end;
    logic         out_valid_reg, out_valid_next;
    logic         out_ok_reg;
    logic [31:0]  out_addr_reg;
    logic         pop;

    // close the current field on a dot or an end of string
    function automatic parse_state_t finish_field(parse_state_t s, logic [2:0] cls);
        parse_state_t r;
        r = s;
        if ((s.neg && s.acc != 9'd0) || s.acc > ACC_MAX) begin
            r.verdict = VD_REJECTED;
        end else if (cls == CLS_DOT) begin
            if (s.field_index == 2'd3 || (s.field_index == 2'd0 && s.acc == 9'd0)) begin
                r.verdict = VD_REJECTED;
            end else begin
                r.octets      = {s.octets[15:0], s.acc[7:0]};
                r.field_index = s.field_index + 2'd1;
                r.phase       = PH_START;
                r.acc         = 9'd0;
                r.neg         = 1'b0;
            end
        end else if (cls == CLS_NUL) begin
            if (s.field_index != 2'd3 || s.acc == 9'd0) begin
                r.verdict = VD_REJECTED;
            end else begin
                r.verdict = VD_ACCEPTED;
            end
        end else begin
            r.verdict = VD_REJECTED;
        end
        return r;
    endfunction

    // one character step of the field machine
    function automatic parse_state_t feed(parse_state_t s, logic [2:0] cls, logic [3:0] dig);
        parse_state_t r;
        parse_state_t z;
        logic [12:0]  sum;
        logic [8:0]   acc_new;
        logic [8:0]   acc_base;
        r        = s;
        z        = s;
        acc_base = (s.phase == PH_DIGITS) ? s.acc : 9'd0;
        sum      = 13'({acc_base, 3'b000}) + 13'({acc_base, 1'b0}) + 13'(dig);
        acc_new  = (sum > 13'(ACC_SAT)) ? ACC_SAT : sum[8:0];
        if (s.verdict == VD_PARSING) begin
            case (s.phase)
                PH_START: begin
                    if (cls == CLS_NUL || cls == CLS_SPTAB) begin
                        r.verdict = VD_REJECTED;
                    end else if (cls == CLS_WS) begin
                        r.phase = PH_WS;
                    end else if (cls == CLS_PLUS || cls == CLS_MINUS) begin
                        r.neg   = (cls == CLS_MINUS);
                        r.phase = PH_SIGN;
                    end else if (cls == CLS_DIGIT) begin
                        r.acc   = acc_new;
                        r.phase = PH_DIGITS;
                    end else if (cls == CLS_DOT) begin
                        z.acc = 9'd0;
                        z.neg = 1'b0;
                        r     = finish_field(z, cls);
                    end else begin
                        r.verdict = VD_REJECTED;
                    end
                end
                PH_WS: begin
                    if (cls == CLS_WS || cls == CLS_SPTAB) begin
                        r.phase = PH_WS;
                    end else if (cls == CLS_PLUS || cls == CLS_MINUS) begin
                        r.neg   = (cls == CLS_MINUS);
                        r.phase = PH_SIGN;
                    end else if (cls == CLS_DIGIT) begin
                        r.acc   = acc_new;
                        r.phase = PH_DIGITS;
                    end else begin
                        r.verdict = VD_REJECTED;
                    end
                end
                PH_SIGN: begin
                    if (cls == CLS_DIGIT) begin
                        r.acc   = acc_new;
                        r.phase = PH_DIGITS;
                    end else begin
                        r.verdict = VD_REJECTED;
                    end
                end
                PH_DIGITS: begin
                    if (cls == CLS_DIGIT) begin
                        r.acc = acc_new;
                    end else begin
                        r = finish_field(s, cls);
                    end
                end
                default: begin
                    r.verdict = VD_REJECTED;
                end
            endcase
        end
        return r;
    endfunction

    // a last byte needs the result register free or draining
    assign pop     = q_valid && (!q_token.last || !out_valid_reg || m_tready);
    assign q_ready = pop;

    always_comb begin
        st_byte = feed(st_reg, q_token.cls, q_token.digit);
        st_end  = feed(st_byte, CLS_NUL, 4'd0);
        st_next = st_reg;
        if (pop) begin
            st_next = q_token.last ? ST_RESET : st_byte;
        end
        out_valid_next = out_valid_reg;
        if (pop && q_token.last) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= ST_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && q_token.last) begin
            out_ok_reg   <= (st_end.verdict == VD_ACCEPTED);
            out_addr_reg <= (st_end.verdict == VD_ACCEPTED) ?
                            {st_end.octets, st_end.acc[7:0]} : 32'd0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_addr_reg;
    assign m_tuser[0] = out_ok_reg;

endmodule

>>> src/ipv4_dotted_quad_parser_core.sv
// top level of the dotted-quad ipv4 address parser
//
// Accepts an address string one byte per transfer on the s_ channel, with
// s_tlast on the final byte, and returns one result per string on the m_
// channel: m_tuser[0] says whether the string is a valid dotted-quad address
// and m_tdata carries the address, first field in bits 31:24, zero when not
// valid. Fields follow base-10 string-to-number rules: optional leading
// whitespace (not starting with space or tab), one optional sign, digits,
// value 0..255; the first and fourth fields must be nonzero, fields two and
// three may be empty. A zero byte ends the string early and later bytes up to
// s_tlast are ignored. The block takes one byte every cycle while the queue has
// room; the figure is set by the per-byte field state machine in the back end,
// which retires one token a cycle unless a last byte waits behind a stalled
// result. Results pass through the two-entry token queue and the result
// register to m_; a waiting result does not keep later bytes out of the queue.
module ipv4_dotted_quad_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_byte
    input  logic        s_tlast,    // last_byte
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] ip_address
    output logic [0:0]  m_tuser     // [0] is_valid
);
    import ipv4dq_pkg::*;

    // classified token from the front end into the queue
    token_t push_token;
    logic   push_valid;
    logic   push_ready;

    // token from the queue to the back end
    token_t q_token;
    logic   q_valid;
    logic   q_ready;

    // byte classification, no state
    ipv4dq_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_token (push_token)
    );

    // decouples byte intake from result backpressure
    ipv4dq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_token  (push_token),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_token (q_token)
    );

    // field state machine and registered result
    ipv4dq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_token  (q_token),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> src/ipv4dq_checker.sv
// port-level checker for the parser, bound to the top level
`include "ipv4_dotted_quad_parser_core_assert.svh"

module ipv4dq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [0:0]  m_tuser
);

    // a stalled result holds
    `IPV4DQ_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // rejected strings report a zero address
    `IPV4DQ_ASSERT_NOW(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == 32'd0)

    // accepted addresses have nonzero first and fourth fields
    `IPV4DQ_ASSERT_NOW(a_accept_ends, aclk, aresetn, m_tvalid && m_tuser[0], (m_tdata[31:24] != 8'd0) && (m_tdata[7:0] != 8'd0))

    // no result right out of reset
    `IPV4DQ_ASSERT_NOW(a_reset_quiet, aclk, aresetn, $rose(aresetn), !m_tvalid)

endmodule

bind ipv4_dotted_quad_parser_core ipv4dq_checker u_checker (.*);
